FILE: hdl/ecmw_pkg.sv
package ecmw_pkg;

	localparam int MEM_WORDS_DEF = 1024;
	localparam int ADDR_WORD_W   = 14;

	localparam logic [15:0] ADDR_WORD_MASK = 16'hFFFC;
	localparam logic [1:0]  AUTOINC_MODE   = 2'h3;

	// window offsets
	localparam logic [2:0] OFF_ADDR_LO = 3'd2;
	localparam logic [2:0] OFF_ADDR_HI = 3'd3;
	localparam logic [2:0] OFF_DATA_HI = 3'd6;
	localparam logic [2:0] OFF_DATA_B3 = 3'd7;

	typedef struct packed {
		logic        mode;
		logic [2:0]  reg_offset;
		logic        wide;
		logic [15:0] write_data;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        bad_access;
	} rsp_t;

	// classified item passed from front to back
	typedef struct packed {
		logic        write;
		logic        wide;
		logic [2:0]  off;
		logic [15:0] wdata;
		logic        bad;
		logic        mem;
		logic        b3;
		logic        addr_wr;
	} item_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ACCESS,
		BK_DIVIDE
	} back_state_t;

endpackage

FILE: hdl/ec_embedded_memory_window.sv
// channel   | ports               | handshake
// ----------+---------------------+-------------------------------------------
// request   | req (req_t)         | taken at clk edge with start=1, busy=0
// result    | rsp (rsp_t)         | done high one cycle, one result per item
//
// After reset a pass clears the shared memory word by word, busy held high.
// Items go through a two-entry queue to the executing back end.
// Address window items complete in the back end's idle state; data window items
// also pass through its access state (single-port RAM: read, then write back on a write).
// Address register writes redo the memory index (reciprocal multiply, then remainder).
// After the clear, busy rises only while the queue is full; results cannot be stalled.
module ec_embedded_memory_window
	import ecmw_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic  hold, pop, avail;
	item_t head;

	ecmw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.hold   (hold),
		.busy   (busy),
		.pop    (pop),
		.avail  (avail),
		.head   (head)
	);

	ecmw_back #(.MEM_WORDS(MEM_WORDS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.head     (head),
		.pop      (pop),
		.clearing (hold),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

FILE: hdl/ecmw_ram.sv
module ecmw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: hdl/ecmw_front.sv
module ecmw_front
	import ecmw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  req_t  req,
	input  logic  hold,
	output logic  busy,
	input  logic  pop,
	output logic  avail,
	output item_t head
);

	item_t      fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.write   = req.mode;
		cls.wide    = req.wide;
		cls.off     = req.reg_offset;
		cls.wdata   = req.write_data;
		cls.bad     = req.wide & req.reg_offset[0];
		cls.mem     = req.reg_offset[2] & ~cls.bad;
		cls.b3      = req.wide ? (req.reg_offset == OFF_DATA_HI)
		                       : (req.reg_offset == OFF_DATA_B3);
		cls.addr_wr = req.mode & ~cls.bad & (req.reg_offset[2:1] == OFF_ADDR_LO[2:1]);
	end

	assign busy  = hold | cnt_q[1];
	assign push  = start & ~busy;
	assign avail = cnt_q != 2'd0;
	assign head  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: hdl/ecmw_back.sv
module ecmw_back
	import ecmw_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  avail,
	input  item_t head,
	output logic  pop,
	output logic  clearing,
	output logic  done,
	output rsp_t  rsp
);

	localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);
	// quotient = (word * RECIP) >> MOD_SH, exact for every 14-bit word address
	localparam int MOD_SH = ADDR_WORD_W + $clog2(MEM_WORDS);
	localparam logic [15:0] RECIP = 16'(((64'd1 << MOD_SH) + MEM_WORDS - 1) / MEM_WORDS);
	localparam logic [ADDR_WORD_W:0] NWORDS = (ADDR_WORD_W + 1)'(MEM_WORDS);

	back_state_t            state_q, state_d;
	logic [15:0]            addr_q, addr_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [IDX_W-1:0]       clr_q, clr_d;
	logic [ADDR_WORD_W-1:0] quot_q, quot_d;
	logic [ADDR_WORD_W-1:0] div_q, div_d;
	logic                   step_q, step_d;
	item_t                  cur_q, cur_d;
	logic                   done_q, done_d;
	rsp_t                   rsp_q, rsp_d;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_addr;
	logic [31:0]            ram_wdata, ram_rdata;

	logic [ADDR_WORD_W+15:0] recip_prod;
	logic [2*ADDR_WORD_W:0]  back_prod;
	logic [IDX_W-1:0]        rem_val;
	logic [IDX_W-1:0]        idx_inc;
	logic [31:0]             shifted, merged;
	logic [15:0]             mem_rd, reg_rd, reg_wr;
	logic [3:0]              ben;

	ecmw_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// word address mod MEM_WORDS: reciprocal multiply, then multiply back and subtract
	always_comb begin
		recip_prod = div_q * RECIP;
		back_prod  = quot_q * NWORDS;
		rem_val    = IDX_W'(div_q - back_prod[ADDR_WORD_W-1:0]);
	end

	// next index after auto-increment; 14-bit wrap lands on entry 0
	assign idx_inc = (&addr_q[15:2] || idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// address register lanes
	always_comb begin
		case (head.off)
			OFF_ADDR_LO: begin
				reg_rd = head.wide ? addr_q : {8'h00, addr_q[7:0]};
				reg_wr = head.wide ? head.wdata : {addr_q[15:8], head.wdata[7:0]};
			end
			OFF_ADDR_HI: begin
				reg_rd = {8'h00, addr_q[15:8]};
				reg_wr = {head.wdata[7:0], addr_q[7:0]};
			end
			default: begin
				reg_rd = 16'h0000;
				reg_wr = addr_q;
			end
		endcase
	end

	// memory data lanes
	always_comb begin
		shifted = ram_rdata >> {cur_q.off[1:0], 3'b000};
		mem_rd  = cur_q.wide ? shifted[15:0] : {8'h00, shifted[7:0]};
		for (int l = 0; l < 4; l++) begin
			ben[l] = (2'(l) == cur_q.off[1:0])
			       | (cur_q.wide & (2'(l) == cur_q.off[1:0] + 2'd1));
			if (!ben[l]) begin
				merged[l*8 +: 8] = ram_rdata[l*8 +: 8];
			end else if (2'(l) == cur_q.off[1:0]) begin
				merged[l*8 +: 8] = cur_q.wdata[7:0];
			end else begin
				merged[l*8 +: 8] = cur_q.wdata[15:8];
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		idx_d     = idx_q;
		clr_d     = clr_q;
		quot_d    = quot_q;
		div_d     = div_q;
		step_d    = step_q;
		cur_d     = cur_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = merged;
		case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = 32'h0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == LAST_IDX) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (avail) begin
					pop   = 1'b1;
					cur_d = head;
					if (head.mem) begin
						// read issued now, data back next cycle
						state_d = BK_ACCESS;
					end else begin
						done_d           = 1'b1;
						rsp_d.bad_access = head.bad;
						rsp_d.read_data  = (head.write | head.bad) ? 16'h0000 : reg_rd;
						if (head.addr_wr) begin
							addr_d  = reg_wr;
							div_d   = reg_wr[15:2];
							step_d  = 1'b0;
							state_d = BK_DIVIDE;
						end
					end
				end
			end
			BK_ACCESS: begin
				ram_we           = cur_q.write;
				done_d           = 1'b1;
				rsp_d.bad_access = 1'b0;
				rsp_d.read_data  = cur_q.write ? 16'h0000 : mem_rd;
				if (cur_q.b3 && addr_q[1:0] == AUTOINC_MODE) begin
					addr_d = ((addr_q & ADDR_WORD_MASK) + 16'd4) | {14'd0, addr_q[1:0]};
					idx_d  = idx_inc;
				end
				state_d = BK_IDLE;
			end
			BK_DIVIDE: begin
				if (!step_q) begin
					quot_d = ADDR_WORD_W'(recip_prod >> MOD_SH);
					step_d = 1'b1;
				end else begin
					idx_d   = rem_val;
					step_d  = 1'b0;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			addr_q  <= 16'h0000;
			idx_q   <= '0;
			clr_q   <= '0;
			step_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			idx_q   <= idx_d;
			clr_q   <= clr_d;
			step_q  <= step_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= quot_d;
		div_q  <= div_d;
		cur_q  <= cur_d;
		rsp_q  <= rsp_d;
	end

	assign clearing = state_q == BK_CLEAR;
	assign done     = done_q;
	assign rsp      = rsp_q;

endmodule

FILE: hdl/ecmw_checker.sv
module ecmw_checker
	import ecmw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	logic [2:0] pending_q;
	logic       accept;

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + {2'd0, accept} - {2'd0, done};
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pending_q != 3'd0)
		else $error("result without an outstanding item");

	a_max_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more items in flight than queue and back end hold");

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 3'd3 && !done) |-> busy)
		else $error("item accepted with queue and back end full");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bad_access) |-> rsp.read_data == 16'h0000)
		else $error("rejected item returned data");

endmodule

bind ec_embedded_memory_window ecmw_checker u_ecmw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ecmw_pkg::*;

	localparam logic DIR_READ  = 1'b0;
	localparam logic DIR_WRITE = 1'b1;
	localparam logic ACC_BYTE  = 1'b0;
	localparam logic ACC_WORD  = 1'b1;

	localparam logic [2:0] OFF_ID_LO   = 3'd0;
	localparam logic [2:0] OFF_ID_HI   = 3'd1;
	localparam logic [2:0] OFF_DATA_B0 = 3'd4;
	localparam logic [2:0] OFF_DATA_B1 = 3'd5;

	localparam int TOTAL_ITEMS  = 1775;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 40;
	localparam int IDLE_PERCENT = 7;

	// Shadow of the window: address register plus the memory store.
	class window_scoreboard;
		logic [15:0] win_addr;
		logic [31:0] mem [MEM_WORDS_DEF];
		rsp_t        replies [$];
		int          mismatches;

		function new();
			win_addr = '0;
			foreach (mem[i])
				mem[i] = '0;
			mismatches = 0;
		endfunction

		function int unsigned word_slot();
			return (int'(win_addr) >> 2) % MEM_WORDS_DEF;
		endfunction

		function logic [7:0] lane_byte(logic [2:0] lane);
			logic [31:0] w;
			w = mem[word_slot()];
			if (lane == OFF_ADDR_LO)
				return win_addr[7:0];
			if (lane == OFF_ADDR_HI)
				return win_addr[15:8];
			if (lane >= OFF_DATA_B0)
				return w[(lane - OFF_DATA_B0) * 8 +: 8];
			return 8'h00;
		endfunction

		function void put_lane(logic [2:0] lane, logic [7:0] v);
			int unsigned slot;
			slot = word_slot();
			if (lane == OFF_ADDR_LO)
				win_addr[7:0] = v;
			else if (lane == OFF_ADDR_HI)
				win_addr[15:8] = v;
			else if (lane >= OFF_DATA_B0)
				mem[slot][(lane - OFF_DATA_B0) * 8 +: 8] = v;
		endfunction

		function void take_access(req_t r);
			rsp_t        want;
			logic        hits_b3;
			logic [2:0]  upper;
			want = '0;
			upper = r.reg_offset | 3'd1;
			if (r.wide == ACC_WORD && r.reg_offset[0]) begin
				want.bad_access = 1'b1;
			end else begin
				hits_b3 = (r.wide == ACC_WORD) ? (r.reg_offset == OFF_DATA_HI)
					: (r.reg_offset == OFF_DATA_B3);
				if (r.wide == ACC_WORD) begin
					if (r.mode == DIR_WRITE) begin
						put_lane(r.reg_offset, r.write_data[7:0]);
						put_lane(upper, r.write_data[15:8]);
					end else begin
						want.read_data = {lane_byte(upper), lane_byte(r.reg_offset)};
					end
				end else if (r.mode == DIR_WRITE) begin
					put_lane(r.reg_offset, r.write_data[7:0]);
				end else begin
					want.read_data = {8'h00, lane_byte(r.reg_offset)};
				end
				// auto-increment keeps the mode bits, word address wraps in 14 bits
				if (hits_b3 && win_addr[1:0] == AUTOINC_MODE)
					win_addr[15:2] = win_addr[15:2] + 14'd1;
			end
			replies.push_back(want);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (replies.size() == 0) begin
				$display("%0t: result with none expected: read_data=%h bad_access=%b",
					$time, got.read_data, got.bad_access);
				mismatches++;
			end else begin
				want = replies.pop_front();
				if (got.read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h",
						$time, want.read_data, got.read_data);
					mismatches++;
				end
				if (got.bad_access !== want.bad_access) begin
					$display("%0t: bad_access expected %b actual %b",
						$time, want.bad_access, got.bad_access);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	window_scoreboard model;
	int items_sent  = 0;
	int stall_count = 0;

	ec_embedded_memory_window uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				model.take_access(req);
			if (done)
				model.check_reply(rsp);
		end
		if ((arst_n && start && !busy) || done) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	// Called just after a falling edge; returns just after a falling edge.
	task automatic bus_access(input logic dir, input logic [2:0] off, input logic w,
		input logic [15:0] data);
		req_t r;
		int   gap;
		r.mode = dir;
		r.reg_offset = off;
		r.wide = w;
		r.write_data = data;
		// random idle gaps, but none in a stretch in the middle of the random part
		if ((items_sent < 700 || items_sent >= 1100)
			&& $urandom_range(0, 99) < IDLE_PERCENT) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic set_window(input logic [13:0] word, input logic [1:0] amode,
		input logic split);
		logic [15:0] a;
		a = {word, amode};
		if (split) begin
			bus_access(DIR_WRITE, OFF_ADDR_LO, ACC_BYTE, {8'($urandom), a[7:0]});
			bus_access(DIR_WRITE, OFF_ADDR_HI, ACC_BYTE, {8'($urandom), a[15:8]});
		end else begin
			bus_access(DIR_WRITE, OFF_ADDR_LO, ACC_WORD, a);
		end
	endtask

	task automatic directed_items();
		bus_access(DIR_READ,  OFF_ID_LO,   ACC_BYTE, 16'hFFFF);
		bus_access(DIR_WRITE, OFF_ID_LO,   ACC_WORD, 16'hFFFF);
		bus_access(DIR_WRITE, OFF_ID_HI,   ACC_BYTE, 16'h00FF);
		bus_access(DIR_READ,  OFF_ID_LO,   ACC_WORD, 16'h0000);
		bus_access(DIR_READ,  OFF_ID_HI,   ACC_BYTE, 16'h0000);
		// odd word accesses are rejected
		bus_access(DIR_WRITE, OFF_ADDR_HI, ACC_WORD, 16'hFFFF);
		bus_access(DIR_READ,  OFF_DATA_B1, ACC_WORD, 16'h0000);
		bus_access(DIR_WRITE, OFF_DATA_B3, ACC_WORD, 16'h1234);
		bus_access(DIR_READ,  OFF_ID_HI,   ACC_WORD, 16'h0000);
		// top word address, mode 3: wraps to word 0
		bus_access(DIR_WRITE, OFF_ADDR_LO, ACC_WORD, 16'hFFFF);
		bus_access(DIR_WRITE, OFF_DATA_B0, ACC_WORD, 16'hBEEF);
		bus_access(DIR_WRITE, OFF_DATA_HI, ACC_WORD, 16'hDEAD);
		bus_access(DIR_READ,  OFF_ADDR_LO, ACC_WORD, 16'h0000);
		bus_access(DIR_WRITE, OFF_ADDR_LO, ACC_BYTE, 16'h00FF);
		bus_access(DIR_WRITE, OFF_ADDR_HI, ACC_BYTE, 16'hAAFF);
		bus_access(DIR_READ,  OFF_DATA_B0, ACC_BYTE, 16'h0000);
		bus_access(DIR_READ,  OFF_DATA_HI, ACC_BYTE, 16'h0000);
		bus_access(DIR_READ,  OFF_DATA_B3, ACC_BYTE, 16'h0000);
		bus_access(DIR_READ,  OFF_DATA_HI, ACC_WORD, 16'h0000);
		// word address past the store aliases onto entry 0
		bus_access(DIR_WRITE, OFF_ADDR_HI, ACC_BYTE, 16'h0010);
		bus_access(DIR_WRITE, OFF_ADDR_LO, ACC_BYTE, 16'h5503);
		bus_access(DIR_WRITE, OFF_DATA_B3, ACC_BYTE, 16'h12A5);
		bus_access(DIR_READ,  OFF_ADDR_HI, ACC_BYTE, 16'h0000);
		// mode 0: no increment
		bus_access(DIR_WRITE, OFF_ADDR_LO, ACC_WORD, 16'h03FC);
		bus_access(DIR_WRITE, OFF_DATA_HI, ACC_WORD, 16'h0000);
		bus_access(DIR_READ,  OFF_DATA_HI, ACC_WORD, 16'h0000);
		bus_access(DIR_READ,  OFF_ADDR_LO, ACC_WORD, 16'h0000);
	endtask

	task automatic random_items();
		int unsigned pick;
		int unsigned reps;
		logic [13:0] word;
		logic [1:0]  amode;
		logic [2:0]  off;
		logic        w;
		logic        dir;
		while (items_sent < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					word = 14'($urandom_range(0, 15));
				else if (pick < 75)
					word = 14'($urandom_range(MEM_WORDS_DEF - 8, MEM_WORDS_DEF + 8));
				else if (pick < 85)
					word = 14'($urandom_range(16370, 16383));
				else
					word = 14'($urandom);
				amode = ($urandom_range(0, 1) == 0) ? AUTOINC_MODE : 2'($urandom_range(0, 2));
				set_window(word, amode, $urandom_range(0, 3) == 0);
				reps = $urandom_range(1, 12);
				repeat (reps) begin
					off = 3'($urandom_range(OFF_DATA_B0, OFF_DATA_B3));
					w = ($urandom_range(0, 99) < 35) ? ACC_WORD : ACC_BYTE;
					if (w == ACC_WORD)
						off[0] = 1'b0;
					dir = ($urandom_range(0, 99) < 60) ? DIR_WRITE : DIR_READ;
					bus_access(dir, off, w, 16'($urandom));
				end
				if ($urandom_range(0, 3) == 0)
					bus_access(DIR_READ, OFF_ADDR_LO, ACC_WORD, 16'($urandom));
			end else begin
				bus_access(1'($urandom), 3'($urandom), 1'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		model = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_items();
		random_items();
		start <= 1'b0;
		while (model.replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.mismatches == 0 && model.replies.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/ecmw_pkg.sv
hdl/ecmw_ram.sv
hdl/ecmw_front.sv
hdl/ecmw_back.sv
hdl/ec_embedded_memory_window.sv
hdl/ecmw_checker.sv
sim/testbench.sv
